### hw/rtl/pwnd_pkg.sv
// Package with the types, constants and helpers of the pulse width nibble decoder.
`default_nettype none
package pwnd_pkg;

    localparam int unsigned WIDTH_W    = 32;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned MESSAGE_W  = 64;
    localparam int unsigned NIBBLE_W   = 4;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [NIBBLE_W-1:0] NIBBLE_TOP_BIT = 4'b1000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SYNC_LOW  = 3'd0,
        REG_SYNC_HIGH = 3'd1,
        REG_END_LIMIT = 3'd2,
        REG_ONE_LOW   = 3'd3,
        REG_ONE_HIGH  = 3'd4,
        REG_ZERO_LOW  = 3'd5,
        REG_ZERO_HIGH = 3'd6
    } t_cfg_reg;

    localparam logic [WIDTH_W-1:0] RST_SYNC_LOW  = 32'd3800;
    localparam logic [WIDTH_W-1:0] RST_SYNC_HIGH = 32'd4200;
    localparam logic [WIDTH_W-1:0] RST_END_LIMIT = 32'd18000;
    localparam logic [WIDTH_W-1:0] RST_ONE_LOW   = 32'd1800;
    localparam logic [WIDTH_W-1:0] RST_ONE_HIGH  = 32'd2200;
    localparam logic [WIDTH_W-1:0] RST_ZERO_LOW  = 32'd800;
    localparam logic [WIDTH_W-1:0] RST_ZERO_HIGH = 32'd1200;

    typedef struct packed {
        logic [WIDTH_W-1:0] pulse_width;
        logic               pos_edge;
        logic               edges_missed;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0]   nibbles_received;
        logic [MESSAGE_W-1:0] message_word;
        logic                 in_sync;
    } t_out;

    typedef struct packed {
        logic [WIDTH_W-1:0] sync_low;
        logic [WIDTH_W-1:0] sync_high;
        logic [WIDTH_W-1:0] end_limit;
        logic [WIDTH_W-1:0] one_low;
        logic [WIDTH_W-1:0] one_high;
        logic [WIDTH_W-1:0] zero_low;
        logic [WIDTH_W-1:0] zero_high;
    } t_cfg;

    function automatic logic in_window(input logic [WIDTH_W-1:0] w,
                                       input logic [WIDTH_W-1:0] lo,
                                       input logic [WIDTH_W-1:0] hi);
        return (w > lo) && (w < hi);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/pulse_width_nibble_decoder.sv
// Top level of the pulse width nibble decoder: input register, decoder, result register.
//
// Each input transaction on i_in_* is one captured edge: the pulse width before
// the edge in timer ticks, a rising-edge flag and a missed-edge flag. Every
// input transaction yields exactly one result transaction on o_out_*, carrying
// the nibble count, the last sixteen nibbles and the sync flag after that edge.
// The edge is held in an input register; once the output register can take it,
// the decoder state is updated by combinational comparison and shift logic and
// the result is loaded into the output register. Throughput is one transaction
// per cycle, limited only by the output register. When the receiver stalls, the
// result waits in the output register, the input register still takes one more
// edge, and o_in_ready drops only when both hold data. Configuration registers
// are written through i_cfg_we, i_cfg_addr and i_cfg_wdata; the user must write
// them only while the block is idle, not enforced by the block. Indexes beyond
// the list are ignored. Reset clears sync, the counter, the nibble assembly, the
// message and both registers' valid flags and restores the default window bounds.
`default_nettype none
module pulse_width_nibble_decoder (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire pwnd_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output pwnd_pkg::t_out                       o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [pwnd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [pwnd_pkg::WIDTH_W-1:0]    i_cfg_wdata
);

    pwnd_pkg::t_cfg cfg;
    pwnd_pkg::t_out next_out;

    logic          r_in_valid;
    pwnd_pkg::t_in r_in;
    logic          r_out_valid;
    pwnd_pkg::t_out r_out;
    logic          step;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    pwnd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pwnd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_edge  (r_in),
        .i_cfg   (cfg),
        .o_next  (next_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (step) begin
            r_out <= next_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

### hw/rtl/pwnd_cfg_regs.sv
// Configuration register file of the pulse width nibble decoder.
`default_nettype none
module pwnd_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [pwnd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [pwnd_pkg::WIDTH_W-1:0]    i_cfg_wdata,
    output pwnd_pkg::t_cfg                      o_cfg
);

    pwnd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_low  <= pwnd_pkg::RST_SYNC_LOW;
            r_cfg.sync_high <= pwnd_pkg::RST_SYNC_HIGH;
            r_cfg.end_limit <= pwnd_pkg::RST_END_LIMIT;
            r_cfg.one_low   <= pwnd_pkg::RST_ONE_LOW;
            r_cfg.one_high  <= pwnd_pkg::RST_ONE_HIGH;
            r_cfg.zero_low  <= pwnd_pkg::RST_ZERO_LOW;
            r_cfg.zero_high <= pwnd_pkg::RST_ZERO_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pwnd_pkg::REG_SYNC_LOW:  r_cfg.sync_low  <= i_cfg_wdata;
                pwnd_pkg::REG_SYNC_HIGH: r_cfg.sync_high <= i_cfg_wdata;
                pwnd_pkg::REG_END_LIMIT: r_cfg.end_limit <= i_cfg_wdata;
                pwnd_pkg::REG_ONE_LOW:   r_cfg.one_low   <= i_cfg_wdata;
                pwnd_pkg::REG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_wdata;
                pwnd_pkg::REG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg_wdata;
                pwnd_pkg::REG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### hw/rtl/pwnd_core.sv
// Decoder state and its combinational update for one captured edge.
`default_nettype none
module pwnd_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire pwnd_pkg::t_in  i_edge,
    input  wire pwnd_pkg::t_cfg i_cfg,
    output pwnd_pkg::t_out o_next
);

    logic                                r_sync;
    logic [pwnd_pkg::COUNT_W-1:0]        r_count;
    logic [pwnd_pkg::NIBBLE_W-1:0]       r_bit_sel;
    logic [pwnd_pkg::NIBBLE_W-1:0]       r_bits;
    logic [pwnd_pkg::MESSAGE_W-1:0]      r_msg;

    logic                                n_sync;
    logic [pwnd_pkg::COUNT_W-1:0]        n_count;
    logic [pwnd_pkg::NIBBLE_W-1:0]       n_bit_sel;
    logic [pwnd_pkg::NIBBLE_W-1:0]       n_bits;
    logic [pwnd_pkg::MESSAGE_W-1:0]      n_msg;

    logic in_sync_win;
    logic in_zero_win;
    logic in_one_win;
    logic above_end;
    logic [pwnd_pkg::NIBBLE_W-1:0] bits_upd;
    logic [pwnd_pkg::NIBBLE_W-1:0] sel_upd;

    assign in_sync_win = pwnd_pkg::in_window(i_edge.pulse_width, i_cfg.sync_low,
                                             i_cfg.sync_high);
    assign in_zero_win = pwnd_pkg::in_window(i_edge.pulse_width, i_cfg.zero_low,
                                             i_cfg.zero_high);
    assign in_one_win  = pwnd_pkg::in_window(i_edge.pulse_width, i_cfg.one_low,
                                             i_cfg.one_high);
    assign above_end   = i_edge.pulse_width > i_cfg.end_limit;

    always_comb begin
        n_sync    = r_sync;
        n_count   = r_count;
        n_bit_sel = r_bit_sel;
        n_bits    = r_bits;
        n_msg     = r_msg;
        bits_upd  = r_bits;
        sel_upd   = r_bit_sel >> 1;
        priority if (!r_sync && i_edge.pos_edge && in_sync_win) begin
            n_sync    = 1'b1;
            n_count   = '0;
            n_bits    = '0;
            n_bit_sel = pwnd_pkg::NIBBLE_TOP_BIT;
            n_msg     = '0;
        end else if (r_sync && i_edge.edges_missed) begin
            n_sync  = 1'b0;
            n_count = '0;
        end else if (r_sync && i_edge.pos_edge) begin
            priority if (above_end) begin
                n_sync  = 1'b0;
                n_count = '0;
            end else if (in_sync_win) begin
                n_count   = '0;
                n_bits    = '0;
                n_bit_sel = pwnd_pkg::NIBBLE_TOP_BIT;
                n_msg     = '0;
            end else begin
                priority if (in_zero_win) begin
                    bits_upd = r_bits & ~r_bit_sel;
                end else if (in_one_win) begin
                    bits_upd = r_bits | r_bit_sel;
                end else begin
                    n_sync = 1'b0;
                end
                if (sel_upd == '0) begin
                    n_msg     = {r_msg[pwnd_pkg::MESSAGE_W-pwnd_pkg::NIBBLE_W-1:0], bits_upd};
                    n_bit_sel = pwnd_pkg::NIBBLE_TOP_BIT;
                    n_bits    = '0;
                    n_count   = r_count + 1'b1;
                end else begin
                    n_bit_sel = sel_upd;
                    n_bits    = bits_upd;
                end
            end
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= 1'b0;
            r_count   <= '0;
            r_bit_sel <= '0;
            r_bits    <= '0;
            r_msg     <= '0;
        end else if (i_step) begin
            r_sync    <= n_sync;
            r_count   <= n_count;
            r_bit_sel <= n_bit_sel;
            r_bits    <= n_bits;
            r_msg     <= n_msg;
        end
    end

    assign o_next.nibbles_received = n_count;
    assign o_next.message_word     = n_msg;
    assign o_next.in_sync          = n_sync;

endmodule
`default_nettype wire

### hw/rtl/pwnd_checker.sv
// Port-level assertions for the pulse width nibble decoder and their bind.
`default_nettype none
module pwnd_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire pwnd_pkg::t_out o_out_data
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the result register is empty");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed or vanished");

    a_accept_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> ##1 o_out_valid)
        else $error("accepted transaction produced no result");

endmodule

bind pulse_width_nibble_decoder pwnd_checker u_pwnd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

### tb/pwnd_decode_checker.sv
// Checker for the pulse width nibble decoder: edge decoding predictor and result comparison.
module pwnd_decode_checker
    import pwnd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    input  logic i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [WIDTH_W-1:0] i_cfg_wdata,
    output int   o_error_count,
    output int   o_results_due
);

    t_cfg                 limits;
    logic                 synced;
    logic [COUNT_W-1:0]   nib_count;
    logic [NIBBLE_W-1:0]  sel_bit;
    logic [NIBBLE_W-1:0]  nib_bits;
    logic [MESSAGE_W-1:0] msg;
    t_out                 decoded_q [$];
    int                   mismatches = 0;
    int                   results_seen = 0;

    function automatic logic strictly_between(input logic [WIDTH_W-1:0] w,
                                              input logic [WIDTH_W-1:0] lo,
                                              input logic [WIDTH_W-1:0] hi);
        return (w > lo) && (w < hi);
    endfunction

    task automatic restart_frame();
        nib_count = '0;
        nib_bits  = '0;
        sel_bit   = NIBBLE_TOP_BIT;
        msg       = '0;
    endtask

    task automatic decode_edge(input t_in e, output t_out r);
        logic [WIDTH_W-1:0] w;
        w = e.pulse_width;
        if (!synced && e.pos_edge &&
            strictly_between(w, limits.sync_low, limits.sync_high)) begin
            synced = 1'b1;
            restart_frame();
        end else if (synced && e.edges_missed) begin
            synced    = 1'b0;
            nib_count = '0;
        end else if (synced && e.pos_edge) begin
            if (w > limits.end_limit) begin
                synced    = 1'b0;
                nib_count = '0;
            end else if (strictly_between(w, limits.sync_low, limits.sync_high)) begin
                restart_frame();
            end else begin
                if (strictly_between(w, limits.zero_low, limits.zero_high)) begin
                    nib_bits = nib_bits & ~sel_bit;
                end else if (strictly_between(w, limits.one_low, limits.one_high)) begin
                    nib_bits = nib_bits | sel_bit;
                end else begin
                    synced = 1'b0;
                end
                sel_bit = sel_bit >> 1;
                if (sel_bit == '0) begin
                    msg       = {msg[MESSAGE_W-NIBBLE_W-1:0], nib_bits};
                    sel_bit   = NIBBLE_TOP_BIT;
                    nib_bits  = '0;
                    nib_count = nib_count + 1'b1;
                end
            end
        end
        r.nibbles_received = nib_count;
        r.message_word     = msg;
        r.in_sync          = synced;
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            limits = '{sync_low: RST_SYNC_LOW, sync_high: RST_SYNC_HIGH,
                       end_limit: RST_END_LIMIT, one_low: RST_ONE_LOW,
                       one_high: RST_ONE_HIGH, zero_low: RST_ZERO_LOW,
                       zero_high: RST_ZERO_HIGH};
            synced    = 1'b0;
            nib_count = '0;
            sel_bit   = '0;
            nib_bits  = '0;
            msg       = '0;
            decoded_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"result %0d arrived with no edge pending: ",
                                  "count %0d msg %h sync %b"},
                                 results_seen, i_out_data.nibbles_received,
                                 i_out_data.message_word, i_out_data.in_sync);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_data.nibbles_received !== want.nibbles_received ||
                        i_out_data.message_word !== want.message_word ||
                        i_out_data.in_sync !== want.in_sync) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"result %0d: expected count %0d msg %h sync %b, ",
                                      "got count %0d msg %h sync %b"},
                                     results_seen, want.nibbles_received,
                                     want.message_word, want.in_sync,
                                     i_out_data.nibbles_received,
                                     i_out_data.message_word, i_out_data.in_sync);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_edge(i_in_data, want);
                decoded_q.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SYNC_LOW:  limits.sync_low  = i_cfg_wdata;
                    REG_SYNC_HIGH: limits.sync_high = i_cfg_wdata;
                    REG_END_LIMIT: limits.end_limit = i_cfg_wdata;
                    REG_ONE_LOW:   limits.one_low   = i_cfg_wdata;
                    REG_ONE_HIGH:  limits.one_high  = i_cfg_wdata;
                    REG_ZERO_LOW:  limits.zero_low  = i_cfg_wdata;
                    REG_ZERO_HIGH: limits.zero_high = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_results_due <= decoded_q.size();
        o_error_count <= mismatches;
    end

endmodule

### tb/tb_pulse_width_nibble_decoder.sv
// Testbench top for the pulse width nibble decoder: edge stimulus, configuration phases and verdict.
module tb_pulse_width_nibble_decoder;
    import pwnd_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE = 3'd7;

    typedef enum {W_ZERO, W_ONE, W_SYNC, W_END, W_BOUND, W_ANY} t_width_kind;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    logic cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [WIDTH_W-1:0]    cfg_wdata;
    int   error_count;
    int   results_due;

    t_cfg limits;
    bit   quiet = 1'b0;
    int   stall_left = 0;
    int   edges_sent = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pulse_width_nibble_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    pwnd_decode_checker u_decode_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .o_error_count (error_count),
        .o_results_due (results_due)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    always @(posedge clk) begin
        if (quiet) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready  <= 1'b1;
            stall_left <= ($urandom_range(2) == 0) ? gap_len() : 0;
        end
    end

    function automatic logic [WIDTH_W-1:0] pick_width(input t_width_kind k);
        logic [WIDTH_W-1:0] lo;
        logic [WIDTH_W-1:0] hi;
        logic [WIDTH_W-1:0] bounds [7];
        lo = '0;
        hi = '0;
        case (k)
            W_ZERO: begin
                lo = limits.zero_low;
                hi = limits.zero_high;
            end
            W_ONE: begin
                lo = limits.one_low;
                hi = limits.one_high;
            end
            W_SYNC: begin
                lo = limits.sync_low;
                hi = limits.sync_high;
            end
            W_END: begin
                if (limits.end_limit == '1) return $urandom;
                return $urandom_range(32'hFFFF_FFFF, limits.end_limit + 1);
            end
            W_BOUND: begin
                bounds = '{limits.sync_low, limits.sync_high, limits.end_limit, limits.one_low,
                           limits.one_high, limits.zero_low, limits.zero_high};
                return bounds[$urandom_range(6)] + WIDTH_W'($urandom_range(2)) - 1'b1;
            end
            default: return $urandom;
        endcase
        if (hi > lo && hi - lo > 1) return $urandom_range(hi - 1, lo + 1);
        return $urandom;
    endfunction

    task automatic send_edge(input logic [WIDTH_W-1:0] w, input logic r, input logic m);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{pulse_width: w, pos_edge: r, edges_missed: m};
        do @(posedge clk); while (!in_ready);
        edges_sent++;
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic set_limits(input t_cfg c);
        logic [CFG_ADDR_W-1:0] addr [8];
        logic [WIDTH_W-1:0]    data [8];
        addr = '{REG_SYNC_LOW, REG_SYNC_HIGH, REG_END_LIMIT, REG_ONE_LOW,
                 REG_ONE_HIGH, REG_ZERO_LOW, REG_ZERO_HIGH, CFG_ADDR_SPARE};
        data = '{c.sync_low, c.sync_high, c.end_limit, c.one_low,
                 c.one_high, c.zero_low, c.zero_high, $urandom};
        wait_results();
        repeat (4) @(posedge clk);
        foreach (addr[k]) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addr[k];
            cfg_wdata <= data[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        limits = c;
    endtask

    function automatic t_cfg random_limits();
        t_cfg c;
        logic [WIDTH_W-1:0] p;
        int step;
        step = ($urandom_range(3) == 0) ? 5000 : 300;
        p = ($urandom_range(3) == 0) ? $urandom_range(32'hF000_0000) : $urandom_range(2000);
        c.zero_low  = p;
        p += $urandom_range(step, 2);
        c.zero_high = p;
        p += $urandom_range(step, 0);
        c.one_low   = p;
        p += $urandom_range(step, 2);
        c.one_high  = p;
        p += $urandom_range(step, 0);
        c.sync_low  = p;
        p += $urandom_range(step, 2);
        c.sync_high = p;
        c.end_limit = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : p + $urandom_range(step, 0);
        return c;
    endfunction

    task automatic send_noise();
        case ($urandom_range(5))
            0: send_edge(pick_width(W_ANY), $urandom_range(1), 1'b1);
            1: send_edge(pick_width(W_BOUND), 1'b1, 1'b0);
            2: send_edge(pick_width(W_SYNC), 1'b1, 1'b0);
            3: send_edge(pick_width(W_END), 1'b1, 1'b0);
            4: send_edge(pick_width(W_ANY), 1'b0, $urandom_range(1));
            default: send_edge(pick_width(W_ANY), 1'b1, 1'b0);
        endcase
    endtask

    task automatic send_frame(input int n_bits, input bit noisy);
        send_edge(pick_width(W_SYNC), 1'b1, 1'b0);
        repeat (n_bits) begin
            if ($urandom_range(3) == 0) send_edge(pick_width(W_ANY), 1'b0, 1'b0);
            if (noisy && $urandom_range(11) == 0) begin
                send_noise();
            end else begin
                send_edge(pick_width($urandom_range(1) ? W_ONE : W_ZERO), 1'b1, 1'b0);
            end
        end
        send_edge(pick_width(W_END), 1'b1, 1'b0);
    endtask

    task automatic run_frames(input int goal, input int max_bits);
        while (edges_sent < goal) begin
            quiet = ($urandom_range(4) == 0);
            if ($urandom_range(9) == 0) begin
                repeat (8) send_noise();
            end else begin
                send_frame($urandom_range(max_bits, 1), $urandom_range(2) == 0);
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_SYNC_LOW;
        cfg_wdata <= '0;
        limits = '{sync_low: RST_SYNC_LOW, sync_high: RST_SYNC_HIGH,
                   end_limit: RST_END_LIMIT, one_low: RST_ONE_LOW,
                   one_high: RST_ONE_HIGH, zero_low: RST_ZERO_LOW,
                   zero_high: RST_ZERO_HIGH};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_edge(32'd4000, 1'b0, 1'b0);
        send_edge(32'd0, 1'b1, 1'b0);
        send_edge(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_edge(32'd3800, 1'b1, 1'b0);
        send_edge(32'd4200, 1'b1, 1'b0);
        send_edge(32'd3801, 1'b1, 1'b0);
        send_edge(32'd1000, 1'b0, 1'b0);
        send_edge(32'd801, 1'b1, 1'b0);
        send_edge(32'd2199, 1'b1, 1'b0);
        send_edge(32'd1801, 1'b1, 1'b0);
        send_edge(32'd1199, 1'b1, 1'b0);
        send_edge(32'd4199, 1'b1, 1'b0);
        send_edge(32'd2000, 1'b1, 1'b0);
        send_edge(32'd5, 1'b0, 1'b1);
        send_edge(32'd4000, 1'b1, 1'b0);
        send_edge(32'd18001, 1'b1, 1'b0);
        send_edge(32'd4000, 1'b1, 1'b0);
        send_edge(32'd18000, 1'b1, 1'b0);
        send_edge(32'd4000, 1'b1, 1'b1);
        send_edge(32'd2000, 1'b1, 1'b0);
        send_edge(32'd2000, 1'b1, 1'b0);
        send_edge(32'd1000, 1'b1, 1'b0);
        send_edge(32'd1500, 1'b1, 1'b0);
        send_edge(32'hFFFF_FFFF, 1'b1, 1'b0);
        wait_results();

        run_frames(150, 24);

        // One long frame pushes the oldest nibbles out of the message word.
        quiet = 1'b1;
        send_frame(120, 1'b0);
        quiet = 1'b0;

        repeat (3) begin
            set_limits(random_limits());
            run_frames(edges_sent + 60, 24);
        end

        set_limits('{sync_low: '0, sync_high: '1, end_limit: '1, one_low: '0,
                     one_high: '0, zero_low: '0, zero_high: '0});
        run_frames(edges_sent + 25, 6);
        set_limits('{sync_low: 32'hFFFF_FFF0, sync_high: '1, end_limit: '0,
                     one_low: '1, one_high: '0, zero_low: '0, zero_high: '1});
        run_frames(edges_sent + 25, 6);
        set_limits('{sync_low: 32'hFFFF_FFFD, sync_high: '1, end_limit: '1,
                     one_low: '0, one_high: '1, zero_low: '0, zero_high: '1});
        run_frames(edges_sent + 25, 6);
        set_limits('{sync_low: 32'hFFFF_FFFD, sync_high: '1, end_limit: 32'hFFFF_FFFE,
                     one_low: '0, one_high: '1, zero_low: '1, zero_high: '0});
        run_frames(edges_sent + 25, 6);

        wait_results();
        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("[pulse_width_nibble_decoder] OK");
        end else begin
            $display("[pulse_width_nibble_decoder] ERROR");
        end
        $finish;
    end

    initial begin
        #(8 * 800_000);
        $display("[pulse_width_nibble_decoder] ERROR");
        $finish;
    end

endmodule
